// ----- design/sfrl_pkg.sv -----
// Package for the serial frame RAM loader: frame constants, depths, widths.
// No dependencies; used by the top level, serial_frame_ram_loader.
package sfrl_pkg;
  localparam int MaxPayload  = 512;
  localparam int RamDepth    = 4096;
  localparam int MaxReadback = 59;
  localparam int PayAw = $clog2(MaxPayload);
  localparam int RamAw = $clog2(RamDepth);

  localparam logic [7:0] START_BYTE  = 8'h55;
  localparam logic [7:0] ACK_BYTE    = 8'h79;
  localparam logic [7:0] NACK_BYTE   = 8'h1F;
  localparam logic [7:0] OP_PING     = 8'h01;
  localparam logic [7:0] OP_WRITE    = 8'h02;
  localparam logic [7:0] OP_READBACK = 8'h03;

  localparam logic CFG_RAM_SIZE   = 1'b0;
  localparam logic CFG_RAM_ENABLE = 1'b1;
endpackage

// ----- design/serial_frame_ram_loader.sv -----
// Top level of the serial frame RAM loader: frame parser, command sequencer.
// Depends on sfrl_pkg and sfrl_ram (payload buffer and target RAM).
//
// Channel | Direction | Signals
// --------+-----------+-------------------------------------------
// in      | input     | in_valid, in_ready, in_func, in_rx_byte
// out     | output    | out_valid, out_ready, out_tx_byte, out_last
// cfg     | input     | cfg_we, cfg_index, cfg_wdata
//
// The checksum byte of a frame starts the command sequencer, which walks the
// payload buffer one byte per cycle through the single RAM read port; a
// READBACK can be held by output stalls. After reset a clearing pass zeroes
// the 4096-entry target RAM, one entry per cycle; no transfer is taken during
// it. The block holds in_ready low while a command runs or a result waits in
// the output register.
module serial_frame_ram_loader (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_wdata
);
  import sfrl_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_HUNT, S_LEN, S_CMD, S_PAY, S_CRC, S_DISC,
    S_HDR0, S_HDR1, S_WCOPY, S_RHDR, S_RDATA, S_RCRC, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic [12:0] ram_size_r;
  logic        ram_en_r;
  logic [15:0] flen_r, flen_nxt;
  logic        lowseen_r, lowseen_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] off_r, off_nxt;
  logic [15:0] rlen_r, rlen_nxt;
  logic [15:0] idx_r, idx_nxt;      // shared step counter
  logic [2:0]  hdr_r, hdr_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic        olast_r, olast_nxt;
  logic        rd_pend_r, rd_pend_nxt;

  // RAM ports
  logic             pw_we, rw_we;
  logic [PayAw-1:0] pw_addr, pr_addr;
  logic [RamAw-1:0] rw_addr, rr_addr;
  logic [7:0]       pw_data, rw_data, p_rdata, r_rdata;

  sfrl_ram #(.Width(8), .Depth(MaxPayload)) u_pay (
    .clk(clk), .we(pw_we), .waddr(pw_addr), .wdata(pw_data),
    .raddr(pr_addr), .rdata(p_rdata)
  );
  sfrl_ram #(.Width(8), .Depth(RamDepth)) u_ram (
    .clk(clk), .we(rw_we), .waddr(rw_addr), .wdata(rw_data),
    .raddr(rr_addr), .rdata(r_rdata)
  );

  logic [16:0] usable, span;
  logic        xfer_in, oslot;

  assign in_ready    = (state_r == S_HUNT || state_r == S_LEN || state_r == S_CMD ||
                        state_r == S_PAY || state_r == S_CRC || state_r == S_DISC)
                       && !ovalid_r;
  assign xfer_in     = in_valid && in_ready;
  assign out_valid   = ovalid_r;
  assign out_tx_byte = obyte_r;
  assign out_last    = olast_r;
  assign oslot       = !ovalid_r || out_ready;

  always_comb begin
    usable = (ram_size_r > 13'(RamDepth)) ? 17'(RamDepth) : {4'd0, ram_size_r};
    span   = {1'b0, off_r} + {1'b0, (cmd_r == OP_WRITE) ? flen_r - 16'd2 : rlen_r};
  end

  always_comb begin
    state_nxt = state_r; flen_nxt = flen_r; lowseen_nxt = lowseen_r;
    cmd_nxt = cmd_r; cnt_nxt = cnt_r; xor_nxt = xor_r; off_nxt = off_r;
    rlen_nxt = rlen_r; idx_nxt = idx_r; hdr_nxt = hdr_r;
    ovalid_nxt = ovalid_r && !out_ready; obyte_nxt = obyte_r; olast_nxt = olast_r;
    rd_pend_nxt = 1'b0;
    pw_we = 1'b0; pw_addr = cnt_r[PayAw-1:0]; pw_data = in_rx_byte;
    pr_addr = idx_r[PayAw-1:0];
    rw_we = 1'b0; rw_addr = idx_r[RamAw-1:0]; rw_data = 8'd0;
    rr_addr = RamAw'(off_r + idx_r);

    unique case (state_r)
      S_CLEAR: begin
        rw_we = 1'b1;
        idx_nxt = idx_r + 16'd1;
        if (idx_r == 16'(RamDepth - 1)) begin
          state_nxt = S_HUNT;
          idx_nxt = '0;
        end
      end
      S_HUNT: if (xfer_in && !in_func && in_rx_byte == START_BYTE) begin
        state_nxt = S_LEN; lowseen_nxt = 1'b0;
      end
      S_LEN: if (xfer_in) begin
        if (in_func) state_nxt = S_HUNT;
        else if (!lowseen_r) begin
          flen_nxt = {8'd0, in_rx_byte}; lowseen_nxt = 1'b1;
        end else begin
          flen_nxt = {in_rx_byte, flen_r[7:0]}; lowseen_nxt = 1'b0;
          state_nxt = S_CMD;
        end
      end
      S_CMD: if (xfer_in) begin
        if (in_func) state_nxt = S_HUNT;
        else begin
          cmd_nxt = in_rx_byte; xor_nxt = in_rx_byte; cnt_nxt = '0;
          if (flen_r > 16'(MaxPayload)) state_nxt = S_DISC;
          else if (flen_r == 16'd0) state_nxt = S_CRC;
          else state_nxt = S_PAY;
        end
      end
      S_DISC: if (xfer_in) begin
        state_nxt = S_HUNT; ovalid_nxt = 1'b1; obyte_nxt = NACK_BYTE; olast_nxt = 1'b1;
      end
      S_PAY: if (xfer_in) begin
        if (in_func) begin
          state_nxt = S_HUNT; ovalid_nxt = 1'b1; obyte_nxt = NACK_BYTE; olast_nxt = 1'b1;
        end else begin
          pw_we = 1'b1;
          xor_nxt = xor_r ^ in_rx_byte;
          cnt_nxt = cnt_r + 16'd1;
          if (cnt_r + 16'd1 >= flen_r) state_nxt = S_CRC;
        end
      end
      S_CRC: if (xfer_in) begin
        ovalid_nxt = 1'b1; obyte_nxt = NACK_BYTE; olast_nxt = 1'b1;
        state_nxt = S_HUNT;
        if (!in_func && in_rx_byte == xor_r) begin
          if (cmd_r == OP_PING) obyte_nxt = ACK_BYTE;
          else if ((cmd_r == OP_WRITE && flen_r >= 16'd2) ||
                   (cmd_r == OP_READBACK && flen_r >= 16'd4)) begin
            ovalid_nxt = 1'b0; idx_nxt = '0; state_nxt = S_HDR0;
          end
        end
      end
      // fetch offset / count bytes from the payload buffer, one per cycle
      S_HDR0: begin
        pr_addr = PayAw'(idx_r);
        if (idx_r != 16'd0) begin
          unique case (idx_r[2:0])
            3'd1: off_nxt[7:0]   = p_rdata;
            3'd2: off_nxt[15:8]  = p_rdata;
            3'd3: rlen_nxt[7:0]  = p_rdata;
            default: rlen_nxt[15:8] = p_rdata;
          endcase
        end
        idx_nxt = idx_r + 16'd1;
        if ((cmd_r == OP_WRITE && idx_r == 16'd2) || idx_r == 16'd4) state_nxt = S_HDR1;
      end
      S_HDR1: begin
        ovalid_nxt = 1'b1; obyte_nxt = NACK_BYTE; olast_nxt = 1'b1; state_nxt = S_HUNT;
        if (ram_en_r && span <= usable) begin
          if (cmd_r == OP_WRITE) begin
            ovalid_nxt = 1'b0; idx_nxt = 16'd2; state_nxt = S_WCOPY;
          end else if (rlen_r <= 16'(MaxReadback)) begin
            ovalid_nxt = 1'b0; hdr_nxt = '0; state_nxt = S_RHDR; xor_nxt = OP_READBACK;
          end
        end
      end
      // copy: read payload at idx, write RAM in the cycle after
      S_WCOPY: begin
        pr_addr = PayAw'(idx_r);
        rw_we = rd_pend_r;
        rw_addr = RamAw'(off_r + idx_r - 16'd3);
        rw_data = p_rdata;
        if (idx_r < flen_r) begin
          idx_nxt = idx_r + 16'd1; rd_pend_nxt = 1'b1;
        end else if (!rd_pend_r) begin
          ovalid_nxt = 1'b1; obyte_nxt = ACK_BYTE; olast_nxt = 1'b1; state_nxt = S_HUNT;
        end else begin
          idx_nxt = idx_r + 16'd1;
        end
      end
      S_RHDR: if (oslot) begin
        ovalid_nxt = 1'b1; olast_nxt = 1'b0;
        unique case (hdr_r)
          3'd0: obyte_nxt = START_BYTE;
          3'd1: obyte_nxt = rlen_r[7:0];
          3'd2: obyte_nxt = rlen_r[15:8];
          default: obyte_nxt = OP_READBACK;
        endcase
        hdr_nxt = hdr_r + 3'd1;
        if (hdr_r == 3'd3) begin
          idx_nxt = '0; state_nxt = (rlen_r == 16'd0) ? S_RCRC : S_RDATA;
        end
      end
      S_RDATA: begin
        // issue read at idx, wait in S_RDATA for the registered read data, then emit
        rd_pend_nxt = 1'b1;
        if (rd_pend_r) begin
          rd_pend_nxt = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: if (oslot) begin
        ovalid_nxt = 1'b1; obyte_nxt = r_rdata; olast_nxt = 1'b0;
        xor_nxt = xor_r ^ r_rdata;
        idx_nxt = idx_r + 16'd1;
        state_nxt = (idx_r + 16'd1 >= rlen_r) ? S_RCRC : S_RDATA;
      end
      S_RCRC: if (oslot) begin
        ovalid_nxt = 1'b1; obyte_nxt = xor_r; olast_nxt = 1'b1; state_nxt = S_HUNT;
      end
      default: state_nxt = S_HUNT;
    endcase
    if (state_r == S_EMIT) rr_addr = RamAw'(off_r + idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; ram_size_r <= 13'd4096; ram_en_r <= 1'b1;
      flen_r <= '0; lowseen_r <= 1'b0; cmd_r <= '0; cnt_r <= '0; xor_r <= '0;
      idx_r <= '0; hdr_r <= '0; ovalid_r <= 1'b0; rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; flen_r <= flen_nxt; lowseen_r <= lowseen_nxt;
      cmd_r <= cmd_nxt; cnt_r <= cnt_nxt; xor_r <= xor_nxt;
      idx_r <= idx_nxt; hdr_r <= hdr_nxt; ovalid_r <= ovalid_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RAM_SIZE:   ram_size_r <= cfg_wdata;
          CFG_RAM_ENABLE: ram_en_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    off_r <= off_nxt; rlen_r <= rlen_nxt;
    obyte_r <= obyte_nxt; olast_r <= olast_nxt;
  end
endmodule

// ----- design/sfrl_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing; sized by parameters.
module sfrl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
